// File: hw/rtl/sal_pkg.sv
`timescale 1ns / 1ps
package sal_pkg;
    localparam int RATE_W = 17;
    localparam int NUM_REGS = 5;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_STATUS = 2'd1,
        OP_LINK   = 2'd2,
        OP_CENSUS = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        REG_INF_UNAWARE = 3'd0,
        REG_INF_AWARE   = 3'd1,
        REG_GAIN_AWARE  = 3'd2,
        REG_LOSE_AWARE  = 3'd3,
        REG_RECOVERY    = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SELF,
        ST_NBR,
        ST_NBR_WAIT,
        ST_NBR_ACC,
        ST_DECIDE,
        ST_WRITE,
        ST_SCAN,
        ST_SCAN_END,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic self_read;
        logic nbr_read;
        logic nbr_capture;
        logic nbr_accum;
        logic decide;
        logic write_node;
        logic write_link;
        logic scan_step;
        logic census_clear;
        logic [1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
    } t_status;
endpackage

// File: hw/rtl/sal_if.sv
`timescale 1ns / 1ps
interface sal_if #(parameter int W = 1);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/sis_awareness_lattice_update.sv
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | opcode, node_x, node_y, link_slot, link_x, link_y, set_*, rand_*
// out     | out | node_infected, node_aware, *_neighbours, *_total
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data (rates, Q1.16)
// Update: four neighbours, two status reads each, one read port.
// Census: one node read per cycle from the status memory.
// After reset a clearing sweep of all SIDE*SIDE nodes runs before the first transfer.
// Output holds until taken; no new item is taken until then.
module sis_awareness_lattice_update #(
    parameter int SIDE = 64,
    parameter int RAND_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sal_if.sink   in_ch,
    sal_if.source out_ch,
    input  logic i_cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sal_pkg::RATE_W-1:0] i_cfg_data
);
    sal_pkg::t_cmd w_cmd;
    sal_pkg::t_status w_status;

    sal_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_opcode(in_ch.data[1:0]),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    sal_datapath #(.SIDE(SIDE), .RAND_BITS(RAND_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(w_cmd), .o_status(w_status),
        .i_opcode(in_ch.data[1:0]),
        .i_node_x(in_ch.data[7:2]),
        .i_node_y(in_ch.data[13:8]),
        .i_link_slot(in_ch.data[15:14]),
        .i_link_x(in_ch.data[21:16]),
        .i_link_y(in_ch.data[27:22]),
        .i_set_infected(in_ch.data[28]),
        .i_set_aware(in_ch.data[29]),
        .i_rand_infect(in_ch.data[45:30]),
        .i_rand_aware(in_ch.data[61:46]),
        .i_rand_recover(in_ch.data[77:62]),
        .i_rand_forget(in_ch.data[93:78]),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_node_infected(out_ch.data[0]),
        .o_node_aware(out_ch.data[1]),
        .o_infected_neighbours(out_ch.data[4:2]),
        .o_aware_neighbours(out_ch.data[7:5]),
        .o_infected_total(out_ch.data[20:8]),
        .o_aware_total(out_ch.data[33:21])
    );
endmodule

// File: hw/rtl/sal_datapath.sv
`timescale 1ns / 1ps
module sal_datapath #(
    parameter int SIDE = 64,
    parameter int RAND_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  sal_pkg::t_cmd i_cmd,
    output sal_pkg::t_status o_status,
    input  logic [1:0] i_opcode,
    input  logic [5:0] i_node_x,
    input  logic [5:0] i_node_y,
    input  logic [1:0] i_link_slot,
    input  logic [5:0] i_link_x,
    input  logic [5:0] i_link_y,
    input  logic i_set_infected,
    input  logic i_set_aware,
    input  logic [15:0] i_rand_infect,
    input  logic [15:0] i_rand_aware,
    input  logic [15:0] i_rand_recover,
    input  logic [15:0] i_rand_forget,
    input  logic i_cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sal_pkg::RATE_W-1:0] i_cfg_data,
    output logic o_node_infected,
    output logic o_node_aware,
    output logic [2:0] o_infected_neighbours,
    output logic [2:0] o_aware_neighbours,
    output logic [12:0] o_infected_total,
    output logic [12:0] o_aware_total
);
    localparam int CW = $clog2(SIDE);
    localparam int NODES = SIDE * SIDE;
    localparam int AW = 2 * CW;
    localparam int NB = 4;
    localparam int CNTW = AW + 1;
    localparam int PW = sal_pkg::RATE_W + 3;
    localparam int DW = 16;

    // status memory: bit1 infected, bit0 aware
    logic [1:0] r_stat [NODES];
    logic r_rew [NODES];
    logic [AW-1:0] r_link [NODES*NB];

    logic [sal_pkg::RATE_W-1:0] r_rate [sal_pkg::NUM_REGS];

    logic [1:0]    r_op;
    logic [CW-1:0] r_x, r_y;
    logic [1:0]    r_lslot;
    logic [AW-1:0] r_ltgt;
    logic          r_set_i, r_set_a;
    logic [DW-1:0] r_ri, r_ra, r_rr, r_rf;

    logic [1:0]    r_self_st;
    logic          r_self_rew;
    logic          r_self_pend;
    logic [1:0]    r_rd_q;
    logic [AW-1:0] r_rd_link;
    logic [2:0]    r_inf_n, r_aw_n;
    logic [1:0]    r_new_st;
    logic [AW:0]   r_scan;
    logic [CNTW-1:0] r_inf_t, r_aw_t;
    logic          r_scan_v;

    logic [CW-1:0] w_mx, w_my;
    logic [AW-1:0] w_self, w_phys, w_rd_addr;
    logic [1:0]    w_dec_st;

    assign w_self = {r_x, r_y};

    always_comb begin
        w_mx = r_x;
        w_my = r_y;
        unique case (i_cmd.slot)
            2'd0: w_mx = r_x - 1'b1;
            2'd1: w_my = r_y - 1'b1;
            2'd2: w_mx = r_x + 1'b1;
            default: w_my = r_y + 1'b1;
        endcase
        w_phys = {w_mx, w_my};
    end

    // single status read port, data registered
    always_comb begin
        if (i_cmd.self_read) w_rd_addr = w_self;
        else if (i_cmd.nbr_read) w_rd_addr = w_phys;
        else if (i_cmd.nbr_capture) w_rd_addr = r_self_rew ? r_rd_link : w_phys;
        else w_rd_addr = r_scan[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate[sal_pkg::REG_INF_UNAWARE] <= 17'd65536;
            r_rate[sal_pkg::REG_INF_AWARE]   <= '0;
            r_rate[sal_pkg::REG_GAIN_AWARE]  <= 17'd6554;
            r_rate[sal_pkg::REG_LOSE_AWARE]  <= '0;
            r_rate[sal_pkg::REG_RECOVERY]    <= 17'd6554;
        end else if (i_cfg_we && (i_cfg_idx < 3'(sal_pkg::NUM_REGS))) begin
            r_rate[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_opcode;
            r_x     <= CW'(i_node_x);
            r_y     <= CW'(i_node_y);
            r_lslot <= i_link_slot;
            r_ltgt  <= {CW'(i_link_x), CW'(i_link_y)};
            r_set_i <= i_set_infected;
            r_set_a <= i_set_aware;
            r_ri    <= i_rand_infect;
            r_ra    <= i_rand_aware;
            r_rr    <= i_rand_recover;
            r_rf    <= i_rand_forget;
        end
    end

    // status and flag memories: clearing sweep, one write port, one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_stat[r_scan[AW-1:0]] <= 2'b00;
            r_rew[r_scan[AW-1:0]]  <= 1'b0;
        end else if (i_cmd.write_node) begin
            r_stat[w_self] <= r_new_st;
        end else if (i_cmd.write_link) begin
            r_rew[w_self] <= 1'b1;
        end
        if (i_cmd.write_link) begin
            r_link[{w_self, r_lslot}] <= r_ltgt;
        end
        if (i_cmd.self_read) begin
            r_self_rew <= r_rew[w_self];
        end
        if (i_cmd.nbr_read) begin
            r_rd_link <= r_link[{w_self, i_cmd.slot}];
        end
        r_rd_q <= r_stat[w_rd_addr];
    end

    logic [PW-1:0] w_pi, w_pa, w_pl;
    logic [sal_pkg::RATE_W-1:0] w_ri_rate, w_ra_rate;
    logic w_pass_i, w_pass_a, w_pass_r, w_pass_f;
    logic [PW+DW-1:0] w_lhs_i, w_lhs_a, w_lhs_r, w_lhs_f;

    always_comb begin
        w_ri_rate = r_self_st[0] ? r_rate[sal_pkg::REG_INF_AWARE]
                                 : r_rate[sal_pkg::REG_INF_UNAWARE];
        w_ra_rate = r_self_st[0] ? r_rate[sal_pkg::REG_LOSE_AWARE]
                                 : r_rate[sal_pkg::REG_GAIN_AWARE];
        w_pi = PW'(r_inf_n) * PW'(w_ri_rate);
        w_pa = PW'(r_aw_n) * PW'(w_ra_rate);
        w_pl = PW'(r_rate[sal_pkg::REG_LOSE_AWARE]);
        // draw * 2^16 < count * rate * 2^RAND_BITS
        w_lhs_i = (PW+DW)'(r_ri) << 16;
        w_lhs_a = (PW+DW)'(r_ra) << 16;
        w_lhs_r = (PW+DW)'(r_rr) << 16;
        w_lhs_f = (PW+DW)'(r_rf) << 16;
        w_pass_i = (w_lhs_i >> RAND_BITS) < (PW+DW)'(w_pi);
        w_pass_a = (w_lhs_a >> RAND_BITS) < (PW+DW)'(w_pa);
        w_pass_r = (w_lhs_r >> RAND_BITS) < (PW+DW)'(r_rate[sal_pkg::REG_RECOVERY]);
        w_pass_f = (w_lhs_f >> RAND_BITS) < (PW+DW)'(w_pl);
    end

    always_comb begin
        w_dec_st = r_self_st;
        if (r_op == sal_pkg::OP_STATUS) begin
            w_dec_st = {r_set_i, r_set_a};
        end else if (!r_self_st[1] && !r_self_st[0]) begin
            if (w_pass_i) w_dec_st = 2'b11;
            else if (w_pass_a) w_dec_st = 2'b01;
        end else if (!r_self_st[1]) begin
            if (w_pass_i) w_dec_st = 2'b11;
            else if (w_pass_a) w_dec_st = 2'b00;
        end else if (w_pass_r) begin
            w_dec_st = {1'b0, w_pass_f ? 1'b0 : r_self_st[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_inf_n <= '0;
            r_aw_n  <= '0;
        end else begin
            if (i_cmd.nbr_capture) r_inf_n <= r_inf_n + 3'(r_rd_q[1]);
            if (i_cmd.nbr_accum) r_aw_n <= r_aw_n + 3'(r_rd_q[0]);
        end
        if (r_self_pend) begin
            r_self_st <= r_rd_q;
        end
        if (i_cmd.decide) begin
            r_new_st <= w_dec_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_scan_v    <= 1'b0;
            r_self_pend <= 1'b0;
        end else begin
            r_scan_v    <= i_cmd.scan_step;
            r_self_pend <= i_cmd.self_read;
            if (i_cmd.census_clear) begin
                r_scan <= '0;
            end else if (i_cmd.clear_step || i_cmd.scan_step) begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.census_clear || i_cmd.load_item) begin
            r_inf_t <= '0;
            r_aw_t  <= '0;
        end else if (r_scan_v) begin
            r_inf_t <= r_inf_t + CNTW'(r_rd_q[1]);
            r_aw_t  <= r_aw_t + CNTW'(r_rd_q[0]);
        end
    end

    assign o_status.clear_done = r_scan[AW];
    assign o_status.scan_done  = r_scan[AW];

    logic w_is_census, w_is_update;
    assign w_is_census = (r_op == sal_pkg::OP_CENSUS);
    assign w_is_update = (r_op == sal_pkg::OP_UPDATE);

    always_comb begin
        o_node_infected = (w_is_census || r_op == sal_pkg::OP_LINK) ? r_self_st[1] : r_new_st[1];
        o_node_aware    = (w_is_census || r_op == sal_pkg::OP_LINK) ? r_self_st[0] : r_new_st[0];
        o_infected_neighbours = w_is_update ? r_inf_n : 3'd0;
        o_aware_neighbours    = w_is_update ? r_aw_n : 3'd0;
        o_infected_total = '0;
        o_aware_total    = '0;
        if (w_is_census) begin
            o_infected_total = (r_inf_t > CNTW'(8191)) ? 13'd8191 : 13'(r_inf_t);
            o_aware_total    = (r_aw_t > CNTW'(8191)) ? 13'd8191 : 13'(r_aw_t);
        end
    end
endmodule

// File: hw/rtl/sal_ctrl.sv
`timescale 1ns / 1ps
module sal_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic [1:0] i_opcode,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  sal_pkg::t_status i_status,
    output sal_pkg::t_cmd o_cmd
);
    sal_pkg::t_state r_state, n_state;
    logic [1:0] r_op, n_op;
    logic [1:0] r_slot, n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sal_pkg::ST_CLEAR;
            r_op    <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_slot  <= n_slot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_slot = r_slot;
        o_cmd = '0;
        o_cmd.slot = r_slot;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            sal_pkg::ST_CLEAR: begin
                if (i_status.clear_done) begin
                    o_cmd.census_clear = 1'b1;
                    n_state = sal_pkg::ST_IDLE;
                end else begin
                    o_cmd.clear_step = 1'b1;
                end
            end
            sal_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_op = i_opcode;
                    n_slot = '0;
                    n_state = sal_pkg::ST_SELF;
                end
            end
            sal_pkg::ST_SELF: begin
                o_cmd.self_read = 1'b1;
                o_cmd.census_clear = 1'b1;
                unique case (r_op)
                    sal_pkg::OP_UPDATE: n_state = sal_pkg::ST_NBR;
                    sal_pkg::OP_STATUS: n_state = sal_pkg::ST_DECIDE;
                    sal_pkg::OP_LINK:   n_state = sal_pkg::ST_WRITE;
                    default:            n_state = sal_pkg::ST_SCAN;
                endcase
            end
            sal_pkg::ST_NBR: begin
                o_cmd.nbr_read = 1'b1;
                // virtual neighbour status of the previous slot is in now
                o_cmd.nbr_accum = (r_slot != 2'd0);
                n_state = sal_pkg::ST_NBR_WAIT;
            end
            sal_pkg::ST_NBR_WAIT: begin
                o_cmd.nbr_capture = 1'b1;
                n_slot = r_slot + 1'b1;
                n_state = (r_slot == 2'd3) ? sal_pkg::ST_NBR_ACC : sal_pkg::ST_NBR;
            end
            sal_pkg::ST_NBR_ACC: begin
                o_cmd.nbr_accum = 1'b1;
                n_state = sal_pkg::ST_DECIDE;
            end
            sal_pkg::ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = sal_pkg::ST_WRITE;
            end
            sal_pkg::ST_WRITE: begin
                if (r_op == sal_pkg::OP_LINK) o_cmd.write_link = 1'b1;
                else o_cmd.write_node = 1'b1;
                n_state = sal_pkg::ST_OUT;
            end
            sal_pkg::ST_SCAN: begin
                if (i_status.scan_done) n_state = sal_pkg::ST_SCAN_END;
                else o_cmd.scan_step = 1'b1;
            end
            sal_pkg::ST_SCAN_END: begin
                n_state = sal_pkg::ST_OUT;
            end
            sal_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = sal_pkg::ST_IDLE;
            end
            default: n_state = sal_pkg::ST_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/sal_checker.sv
`timescale 1ns / 1ps
module sal_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [33:0] i_out_data
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data)) else $error("result changed");
    a_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data[4:2] <= 3'd4) else $error("neighbour count range");
    a_aw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data[7:5] <= 3'd4) else $error("aware count range");
endmodule

bind sis_awareness_lattice_update sal_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
    .i_out_data(out_ch.data[33:0])
);

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
    // field order puts opcode at the low end of the transfer
    typedef struct packed {
        logic [15:0]      rand_forget;
        logic [15:0]      rand_recover;
        logic [15:0]      rand_aware;
        logic [15:0]      rand_infect;
        logic             set_aware;
        logic             set_infected;
        logic [5:0]       link_y;
        logic [5:0]       link_x;
        logic [1:0]       link_slot;
        logic [5:0]       node_y;
        logic [5:0]       node_x;
        sal_pkg::t_opcode opcode;
    } t_cmd_item;

    typedef struct packed {
        logic [12:0] aware_total;
        logic [12:0] infected_total;
        logic [2:0]  aware_nbrs;
        logic [2:0]  infected_nbrs;
        logic        node_aware;
        logic        node_infected;
    } t_node_result;

    typedef struct {
        t_cmd_item    item;
        bit           fixed;
        t_node_result want;
    } t_dir_row;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [sal_pkg::RATE_W-1:0] RATE_ONE = 17'd65536;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [sal_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [sal_pkg::RATE_W-1:0] i_cfg_data = '0;

    sal_if #(.W($bits(t_cmd_item))) in_ch ();
    sal_if #(.W($bits(t_node_result))) out_ch ();

    sis_awareness_lattice_update dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // lattice mirror
    bit [sal_pkg::RATE_W-1:0] rate_reg [sal_pkg::NUM_REGS];
    bit              infected_map [4096];
    bit              aware_map [4096];
    bit              rewired_map [4096];
    bit [11:0]       link_map [16384];

    t_node_result pending_results [$];
    int errors = 0;
    int tx_idle = 0;
    int rx_idle = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    function automatic bit draw_below(input bit [15:0] draw, input int count,
                                      input bit [sal_pkg::RATE_W-1:0] rate);
        longint prod;
        prod = longint'(count) * longint'(rate);
        return longint'(draw) < prod;
    endfunction

    function automatic t_node_result lattice_step(input t_cmd_item it);
        t_node_result r;
        bit [11:0] self_idx;
        bit [11:0] phys [4];
        bit [11:0] virt;
        int inf_n;
        int aw_n;
        int inf_t;
        int aw_t;
        r = '0;
        inf_n = 0;
        aw_n = 0;
        inf_t = 0;
        aw_t = 0;
        self_idx = {it.node_x, it.node_y};
        phys[0] = {it.node_x - 6'd1, it.node_y};
        phys[1] = {it.node_x, it.node_y - 6'd1};
        phys[2] = {it.node_x + 6'd1, it.node_y};
        phys[3] = {it.node_x, it.node_y + 6'd1};
        case (it.opcode)
            sal_pkg::OP_UPDATE: begin
                for (int m = 0; m < 4; m++) begin
                    virt = rewired_map[self_idx] ? link_map[{self_idx, 2'(m)}] : phys[m];
                    inf_n += infected_map[phys[m]];
                    aw_n += aware_map[virt];
                end
                if (!infected_map[self_idx] && !aware_map[self_idx]) begin
                    if (draw_below(it.rand_infect, inf_n,
                                   rate_reg[sal_pkg::REG_INF_UNAWARE])) begin
                        infected_map[self_idx] = 1;
                        aware_map[self_idx] = 1;
                    end else if (draw_below(it.rand_aware, aw_n,
                                            rate_reg[sal_pkg::REG_GAIN_AWARE])) begin
                        aware_map[self_idx] = 1;
                    end
                end else if (!infected_map[self_idx]) begin
                    if (draw_below(it.rand_infect, inf_n,
                                   rate_reg[sal_pkg::REG_INF_AWARE])) begin
                        infected_map[self_idx] = 1;
                    end else if (draw_below(it.rand_aware, aw_n,
                                            rate_reg[sal_pkg::REG_LOSE_AWARE])) begin
                        aware_map[self_idx] = 0;
                    end
                end else if (draw_below(it.rand_recover, 1,
                                        rate_reg[sal_pkg::REG_RECOVERY])) begin
                    infected_map[self_idx] = 0;
                    if (draw_below(it.rand_forget, 1, rate_reg[sal_pkg::REG_LOSE_AWARE]))
                        aware_map[self_idx] = 0;
                end
            end
            sal_pkg::OP_STATUS: begin
                infected_map[self_idx] = it.set_infected;
                aware_map[self_idx] = it.set_aware;
            end
            sal_pkg::OP_LINK: begin
                link_map[{self_idx, it.link_slot}] = {it.link_x, it.link_y};
                rewired_map[self_idx] = 1;
            end
            default: begin
                for (int n = 0; n < 4096; n++) begin
                    inf_t += infected_map[n];
                    aw_t += aware_map[n];
                end
                if (inf_t > 8191) inf_t = 8191;
                if (aw_t > 8191) aw_t = 8191;
            end
        endcase
        r.node_infected = infected_map[self_idx];
        r.node_aware = aware_map[self_idx];
        r.infected_nbrs = 3'(inf_n);
        r.aware_nbrs = 3'(aw_n);
        r.infected_total = 13'(inf_t);
        r.aware_total = 13'(aw_t);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_node_result got;
        t_node_result want;
        if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.node_infected !== want.node_infected)
                    report_mismatch("node_infected", got.node_infected, want.node_infected);
                if (got.node_aware !== want.node_aware)
                    report_mismatch("node_aware", got.node_aware, want.node_aware);
                if (got.infected_nbrs !== want.infected_nbrs)
                    report_mismatch("infected_neighbours", got.infected_nbrs,
                                    want.infected_nbrs);
                if (got.aware_nbrs !== want.aware_nbrs)
                    report_mismatch("aware_neighbours", got.aware_nbrs, want.aware_nbrs);
                if (got.infected_total !== want.infected_total)
                    report_mismatch("infected_total", got.infected_total,
                                    want.infected_total);
                if (got.aware_total !== want.aware_total)
                    report_mismatch("aware_total", got.aware_total, want.aware_total);
            end
        end
    end

    // result sink with random stalls and long hold-offs
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    task automatic send_item(input t_cmd_item it, input bit fixed, input t_node_result want);
        t_node_result pred;
        while ($urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        pred = lattice_step(it);
        pending_results.push_back(fixed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_rate(input sal_pkg::t_reg_idx idx,
                              input bit [sal_pkg::RATE_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        rate_reg[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all_rates(input int mode);
        for (int r = 0; r < sal_pkg::NUM_REGS; r++) begin
            case (mode)
                0: write_rate(sal_pkg::t_reg_idx'(r), 17'd0);
                1: write_rate(sal_pkg::t_reg_idx'(r), RATE_ONE);
                default: write_rate(sal_pkg::t_reg_idx'(r), 17'($urandom_range(0, 65536)));
            endcase
        end
    endtask

    function automatic t_cmd_item mk(input sal_pkg::t_opcode op, input int x, input int y,
                                     input int slot, input int lx, input int ly,
                                     input bit si, input bit sa, input int ri,
                                     input int ra, input int rr, input int rf);
        t_cmd_item it;
        it.opcode = op;
        it.node_x = 6'(x);
        it.node_y = 6'(y);
        it.link_slot = 2'(slot);
        it.link_x = 6'(lx);
        it.link_y = 6'(ly);
        it.set_infected = si;
        it.set_aware = sa;
        it.rand_infect = 16'(ri);
        it.rand_aware = 16'(ra);
        it.rand_recover = 16'(rr);
        it.rand_forget = 16'(rf);
        return it;
    endfunction

    function automatic t_node_result mk_res(input bit inf, input bit aw, input int inf_n,
                                            input int aw_n, input int inf_t, input int aw_t);
        t_node_result r;
        r.node_infected = inf;
        r.node_aware = aw;
        r.infected_nbrs = 3'(inf_n);
        r.aware_nbrs = 3'(aw_n);
        r.infected_total = 13'(inf_t);
        r.aware_total = 13'(aw_t);
        return r;
    endfunction

    // nodes cluster around the wrap corner so neighbours interact
    function automatic int pick_coord();
        if ($urandom_range(99) < 30) return $urandom_range(0, 63);
        return (61 + $urandom_range(0, 5)) % 64;
    endfunction

    function automatic t_cmd_item random_item(input sal_pkg::t_opcode op);
        t_cmd_item it;
        it = '0;
        it.opcode = op;
        it.node_x = 6'(pick_coord());
        it.node_y = 6'(pick_coord());
        it.link_slot = 2'($urandom);
        it.link_x = 6'($urandom);
        it.link_y = 6'($urandom);
        it.set_infected = 1'($urandom);
        it.set_aware = 1'($urandom);
        it.rand_infect = 16'($urandom);
        it.rand_aware = 16'($urandom);
        it.rand_recover = 16'($urandom);
        it.rand_forget = 16'($urandom);
        if ($urandom_range(3) == 0) it.rand_infect = 16'($urandom_range(0, 15000));
        if ($urandom_range(3) == 0) it.rand_aware = 16'($urandom_range(0, 15000));
        return it;
    endfunction

    task automatic run_random(input int count);
        t_cmd_item it;
        int sel;
        int n;
        n = 0;
        while (n < count) begin
            sel = $urandom_range(99);
            if (sel < 60) begin
                send_item(random_item(sal_pkg::OP_UPDATE), 0, '0);
                n++;
            end else if (sel < 83) begin
                send_item(random_item(sal_pkg::OP_STATUS), 0, '0);
                n++;
            end else if (sel < 97) begin
                // a single link rewires a node, so all four link slots are sent
                it = random_item(sal_pkg::OP_LINK);
                for (int s = 0; s < 4; s++) begin
                    it.link_slot = 2'(s);
                    it.link_x = 6'(pick_coord());
                    it.link_y = 6'(pick_coord());
                    send_item(it, 0, '0);
                end
                n += 4;
            end else begin
                send_item(random_item(sal_pkg::OP_CENSUS), 0, '0);
                n++;
            end
        end
    endtask

    t_dir_row dir_rows [$];

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        rate_reg[sal_pkg::REG_INF_UNAWARE] = RATE_ONE;
        rate_reg[sal_pkg::REG_INF_AWARE] = 17'd0;
        rate_reg[sal_pkg::REG_GAIN_AWARE] = 17'd6554;
        rate_reg[sal_pkg::REG_LOSE_AWARE] = 17'd0;
        rate_reg[sal_pkg::REG_RECOVERY] = 17'd6554;

        dir_rows.push_back('{mk(sal_pkg::OP_CENSUS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                             mk_res(0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk(sal_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                             mk_res(0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk(sal_pkg::OP_STATUS, 63, 63, 3, 63, 63, 1, 1, 65535, 65535,
                                65535, 65535), 1, mk_res(1, 1, 0, 0, 0, 0)});
        dir_rows.push_back('{mk(sal_pkg::OP_STATUS, 0, 63, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1,
                             mk_res(1, 0, 0, 0, 0, 0)});
        // one infected neighbour across the wrap, unaware rate is one
        dir_rows.push_back('{mk(sal_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 65535, 0, 0, 0), 1,
                             mk_res(1, 1, 1, 0, 0, 0)});
        dir_rows.push_back('{mk(sal_pkg::OP_UPDATE, 63, 0, 0, 0, 0, 0, 0, 65535, 0, 0, 0),
                             0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_UPDATE, 1, 0, 0, 0, 0, 0, 0, 40000, 100, 0, 0),
                             0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_LINK, 5, 5, 0, 63, 63, 1, 1, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_LINK, 5, 5, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_LINK, 5, 5, 2, 0, 63, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_LINK, 5, 5, 3, 2, 2, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_UPDATE, 5, 5, 0, 0, 0, 0, 0, 65535, 1000, 0, 0),
                             0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_UPDATE, 5, 5, 0, 0, 0, 0, 0, 0, 0, 65535, 65535),
                             0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_UPDATE, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6553, 0),
                             0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_STATUS, 42, 21, 2, 42, 21, 0, 1, 0, 0, 0, 0),
                             0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_UPDATE, 42, 21, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, '0});
        dir_rows.push_back('{mk(sal_pkg::OP_CENSUS, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, '0});

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle = 21;
        rx_idle = 48;
        foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].fixed, dir_rows[k].want);
        drain();

        write_all_rates(1);
        hold_cycles = 400;
        run_random(150);
        drain();

        tx_idle = 48;
        rx_idle = 21;
        write_all_rates(0);
        run_random(100);
        drain();

        write_all_rates(2);
        run_random(130);
        drain();

        tx_idle = 0;
        rx_idle = 0;
        write_all_rates(2);
        run_random(150);
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
